### src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define WLE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define WLE_ASSERT(lbl, prop, msg) `WLE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### src/wle_pkg.sv
package wle_pkg;

  localparam int MAX_TARGET = 62;
  localparam int LEN_W      = $clog2(MAX_TARGET + 1);
  localparam int ADDR_W     = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int KPOS_W     = 4;

  localparam logic [KPOS_W-1:0] KW_EN_LAST = KPOS_W'(7);   // "REDIRECT" has 8 letters
  localparam logic [KPOS_W-1:0] KW_NL_LAST = KPOS_W'(13);  // "DOORVERWIJZING" has 14

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  typedef enum logic [2:0] {
    OUT_KIND_R,
    OUT_KIND_L,
    OUT_TARGET,
    OUT_PCT,
    OUT_DECODED,
    OUT_NUL
  } out_sel_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX1,
    RD_IDX2
  } rd_sel_e;

  // classification of the incoming word
  typedef struct packed {
    logic doc_start;
    logic lbr;
    logic ends;      // ']' or '|'
    logic hash;
    logic space;
    logic abandon;   // ':', newline or NUL
    logic upper_r;
    logic upper_d;
    logic kw_en_hit;
    logic kw_nl_hit;
  } byte_class_t;

  typedef struct packed {
    logic              clr_target;
    logic              append;
    logic [KPOS_W-1:0] kpos;
    logic              rd_en;
    rd_sel_e           rd_sel;
    logic              idx_clr;
    logic              idx_inc1;
    logic              idx_inc3;
    logic              save_h1;
    logic              out_load;
    out_sel_e          out_sel;
  } dp_cmd_t;

  typedef struct packed {
    byte_class_t cls;
    logic        idx_end;
    logic        pct_ok;
    logic        hex_ok;
    logic        dec_drop;
    logic        out_free;
  } dp_stat_t;

  function automatic logic [7:0] kw_en_char(input logic [KPOS_W-1:0] p);
    logic [7:0] ch;
    unique case (p)
      4'd0:    ch = 8'h52;  // R
      4'd1:    ch = 8'h45;  // E
      4'd2:    ch = 8'h44;  // D
      4'd3:    ch = 8'h49;  // I
      4'd4:    ch = 8'h52;  // R
      4'd5:    ch = 8'h45;  // E
      4'd6:    ch = 8'h43;  // C
      4'd7:    ch = 8'h54;  // T
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_nl_char(input logic [KPOS_W-1:0] p);
    logic [7:0] ch;
    unique case (p)
      4'd0:    ch = 8'h44;  // D
      4'd1:    ch = 8'h4F;  // O
      4'd2:    ch = 8'h4F;  // O
      4'd3:    ch = 8'h52;  // R
      4'd4:    ch = 8'h56;  // V
      4'd5:    ch = 8'h45;  // E
      4'd6:    ch = 8'h52;  // R
      4'd7:    ch = 8'h57;  // W
      4'd8:    ch = 8'h49;  // I
      4'd9:    ch = 8'h4A;  // J
      4'd10:   ch = 8'h5A;  // Z
      4'd11:   ch = 8'h49;  // I
      4'd12:   ch = 8'h4E;  // N
      4'd13:   ch = 8'h47;  // G
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b1, 4'(c - 8'h57)};
    end else begin
      v = 5'd0;
    end
    return v;
  endfunction

endpackage

### src/wle_dp.sv
module wle_dp import wle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_byte_i,
  input  logic       doc_start_i,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       truncated_o
);

  logic [7:0]        mem [MAX_TARGET];
  logic [7:0]        rdata_q;
  logic [LEN_W-1:0]  len_q, trim_q, idx_q;
  logic              ovf_q;
  logic [4:0]        h1_q;
  logic              out_valid_q, out_last_q, out_trunc_q;
  logic [7:0]        out_byte_q;

  logic [LEN_W:0]    idx_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic [4:0]        h2;
  logic [7:0]        decoded;
  logic [7:0]        out_byte_d;

  assign idx_ext = {1'b0, idx_q};
  assign h2      = hex_val(rdata_q);
  assign decoded = {h1_q[3:0], h2[3:0]};

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX1: rd_addr = ADDR_W'(idx_ext + (LEN_W+1)'(1));
      RD_IDX2: rd_addr = ADDR_W'(idx_ext + (LEN_W+1)'(2));
      default: rd_addr = ADDR_W'(idx_ext);
    endcase
  end

  // byte classes for the parser, plus status for the record emitter
  always_comb begin
    stat_o.cls.doc_start = doc_start_i;
    stat_o.cls.lbr       = (text_byte_i == CH_LBR);
    stat_o.cls.ends      = (text_byte_i == CH_RBR) || (text_byte_i == CH_PIPE);
    stat_o.cls.hash      = (text_byte_i == CH_HASH);
    stat_o.cls.space     = (text_byte_i == CH_SPACE);
    stat_o.cls.abandon   = (text_byte_i == CH_COLON) || (text_byte_i == CH_NL) ||
                           (text_byte_i == CH_NUL);
    stat_o.cls.upper_r   = (text_byte_i == CH_UP_R);
    stat_o.cls.upper_d   = (text_byte_i == CH_UP_D);
    stat_o.cls.kw_en_hit = (text_byte_i == kw_en_char(cmd_i.kpos));
    stat_o.cls.kw_nl_hit = (text_byte_i == kw_nl_char(cmd_i.kpos));
    stat_o.idx_end       = (idx_q >= trim_q);
    stat_o.pct_ok        = (rdata_q == CH_PCT) &&
                           ((idx_ext + (LEN_W+1)'(2)) < {1'b0, trim_q});
    stat_o.hex_ok        = h1_q[4] && h2[4];
    stat_o.dec_drop      = (decoded == CH_NUL) || (decoded == CH_NL);
    stat_o.out_free      = !out_valid_q || out_ready_i;
  end

  always_comb begin
    unique case (cmd_i.out_sel)
      OUT_KIND_R:  out_byte_d = CH_LO_R;
      OUT_KIND_L:  out_byte_d = CH_LO_L;
      OUT_TARGET:  out_byte_d = (rdata_q == CH_US) ? CH_SPACE : rdata_q;
      OUT_PCT:     out_byte_d = CH_PCT;
      OUT_DECODED: out_byte_d = decoded;
      default:     out_byte_d = CH_NUL;
    endcase
  end

  // target buffer: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !cmd_i.clr_target && (len_q < LEN_W'(MAX_TARGET))) begin
      mem[ADDR_W'(len_q)] <= text_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      trim_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.clr_target) begin
      len_q  <= '0;
      trim_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.append) begin
      if (len_q < LEN_W'(MAX_TARGET)) begin
        len_q <= len_q + LEN_W'(1);
        // trimmed length follows the last non-space byte kept
        if (text_byte_i != CH_SPACE) begin
          trim_q <= len_q + LEN_W'(1);
        end
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc3) begin
      idx_q <= idx_q + LEN_W'(3);
    end else if (cmd_i.idx_inc1) begin
      idx_q <= idx_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_h1) begin
      h1_q <= hex_val(rdata_q);
    end
    if (cmd_i.out_load) begin
      out_byte_q  <= out_byte_d;
      out_last_q  <= (cmd_i.out_sel == OUT_NUL);
      out_trunc_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;
  assign truncated_o = out_trunc_q;

endmodule

### src/wle_ctrl.sv
module wle_ctrl import wle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_PARSE,
    S_KIND,
    S_RD,
    S_CHK,
    S_H1,
    S_H2,
    S_NUL
  } state_e;

  typedef enum logic [2:0] {
    M_TEXT,
    M_HASH,
    M_KW_EN,
    M_KW_NL,
    M_REDIR,
    M_OPEN1,
    M_START,
    M_LINK
  } mode_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic              redir_q, redir_d;
  logic              kind_r_q, kind_r_d;
  logic [KPOS_W-1:0] kpos_q, kpos_d;

  byte_class_t cls;
  assign cls        = stat_i.cls;
  assign in_ready_o = (state_q == S_PARSE);

  always_comb begin
    mode_e m;
    logic  r;
    logic  rescan;

    state_d  = state_q;
    mode_d   = mode_q;
    redir_d  = redir_q;
    kind_r_d = kind_r_q;
    kpos_d   = kpos_q;
    m        = mode_q;
    r        = redir_q;
    rescan   = 1'b0;

    cmd_o            = '0;
    cmd_o.kpos       = kpos_q;
    cmd_o.rd_sel     = RD_IDX;
    cmd_o.out_sel    = OUT_NUL;

    unique case (state_q)
      S_PARSE: begin
        if (in_valid_i) begin
          if (cls.doc_start) begin
            m                = M_TEXT;
            r                = 1'b0;
            kpos_d           = '0;
            cmd_o.clr_target = 1'b1;
          end
          mode_d = m;
          unique case (m)
            M_TEXT, M_REDIR: begin
              if (m == M_REDIR && !cls.space && !cls.lbr) begin
                r = 1'b0;
              end
              if (cls.lbr) begin
                mode_d = M_OPEN1;
              end else if (cls.hash) begin
                mode_d = M_HASH;
              end else if (m == M_REDIR && cls.space) begin
                mode_d = M_REDIR;
              end else begin
                mode_d = M_TEXT;
              end
            end
            M_HASH: begin
              if (cls.upper_r) begin
                mode_d = M_KW_EN;
                kpos_d = KPOS_W'(1);
              end else if (cls.upper_d) begin
                mode_d = M_KW_NL;
                kpos_d = KPOS_W'(1);
              end else begin
                rescan = 1'b1;
              end
            end
            M_KW_EN, M_KW_NL: begin
              if ((m == M_KW_EN) ? cls.kw_en_hit : cls.kw_nl_hit) begin
                kpos_d = kpos_q + KPOS_W'(1);
                if (kpos_q == ((m == M_KW_EN) ? KW_EN_LAST : KW_NL_LAST)) begin
                  r      = 1'b1;
                  mode_d = M_REDIR;
                end
              end else begin
                rescan = 1'b1;
              end
            end
            M_OPEN1: begin
              if (!cls.lbr) begin
                r      = 1'b0;
                rescan = 1'b1;
              end else begin
                mode_d           = M_START;
                cmd_o.clr_target = 1'b1;
              end
            end
            default: begin  // M_START, M_LINK
              if (m == M_START && cls.hash) begin
                r      = 1'b0;
                mode_d = M_TEXT;
              end else if (m == M_START && (cls.space || cls.lbr)) begin
                mode_d = M_START;
              end else if (cls.ends || cls.hash) begin
                kind_r_d = r;
                r        = 1'b0;
                mode_d   = M_TEXT;
                state_d  = S_KIND;
              end else if (cls.abandon) begin
                mode_d = M_TEXT;
              end else begin
                cmd_o.append = 1'b1;
                mode_d       = M_LINK;
              end
            end
          endcase
          // failed match: look at the same word again as plain text
          if (rescan) begin
            if (cls.lbr) begin
              mode_d = M_OPEN1;
            end else if (cls.hash) begin
              mode_d = M_HASH;
            end else begin
              mode_d = M_TEXT;
            end
          end
          redir_d = r;
        end
      end
      S_KIND: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = kind_r_q ? OUT_KIND_R : OUT_KIND_L;
          cmd_o.idx_clr  = 1'b1;
          state_d        = S_RD;
        end
      end
      S_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_NUL;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.pct_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX1;
          state_d      = S_H1;
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_TARGET;
          cmd_o.idx_inc1 = 1'b1;
          state_d        = S_RD;
        end
      end
      S_H1: begin
        cmd_o.save_h1 = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_IDX2;
        state_d       = S_H2;
      end
      S_H2: begin
        if (stat_i.hex_ok) begin
          if (stat_i.dec_drop) begin
            cmd_o.idx_inc3 = 1'b1;
            state_d        = S_RD;
          end else if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = OUT_DECODED;
            cmd_o.idx_inc3 = 1'b1;
            state_d        = S_RD;
          end
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_PCT;
          cmd_o.idx_inc1 = 1'b1;
          state_d        = S_RD;
        end
      end
      default: begin  // S_NUL
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_NUL;
          state_d        = S_PARSE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_PARSE;
      mode_q   <= M_TEXT;
      redir_q  <= 1'b0;
      kind_r_q <= 1'b0;
      kpos_q   <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      redir_q  <= redir_d;
      kind_r_q <= kind_r_d;
      kpos_q   <= kpos_d;
    end
  end

endmodule

### src/wiki_link_extractor.sv
// Wiki link extractor. Markup text enters one word per cycle while the block
// is scanning. When a [[target]] link closes, input stalls while the record
// goes out: the kind letter ('r' redirect, 'l' link), each kept target byte
// (registered read of the 62-entry target buffer, then present), each %XX
// escape, and the NUL terminator that carries last. Trailing spaces are
// trimmed as the target is stored, so no backward scan is needed. truncated
// is set on every word of a record whose target ran past 62 bytes. A waiting
// output word does not block the next input word once the terminator has
// been loaded.
module wiki_link_extractor import wle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       doc_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       truncated_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_byte_i (text_byte_i),
    .doc_start_i (doc_start_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .truncated_o (truncated_o)
  );

endmodule

### src/wle_checker.sv
`include "assert_macros.svh"

module wle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] text_byte_i,
  input logic       doc_start_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic       truncated_o
);

  logic [8:0] in_word;
  logic [9:0] out_word;
  assign in_word  = {text_byte_i, doc_start_i};
  assign out_word = {out_byte_o, last_o, truncated_o};

  `WLE_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word), "stalled input word changed")
  `WLE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output word dropped")
  `WLE_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_word), "stalled output word changed")
  // the terminator is always NUL
  `WLE_ASSERT(a_last_nul, out_valid_o && last_o |-> out_byte_o == 8'h00, "last word not NUL")
  // mid-record, the parser is busy emitting and takes no input
  `WLE_ASSERT(a_busy_mid_record, out_valid_o && !last_o |-> !in_ready_o, "input taken mid-record")

endmodule

bind wiki_link_extractor wle_checker u_wle_checker (.*);
